@@ sv/ibb_pkg.sv @@
// Shared types and constants for the integral box blur unit.
// No dependencies; every other file of the block imports this package.
package ibb_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int MAX_RADIUS   = 7;
  localparam int STORE_ROWS   = 2 * MAX_RADIUS + 1;
  localparam int SLOT_W       = $clog2(STORE_ROWS);
  localparam int STORE_DEPTH  = STORE_ROWS * MAX_WIDTH;
  localparam int STORE_AW     = SLOT_W + COL_W;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int CS_W         = 12;
  localparam int WIN_W        = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef logic [2:0][7:0] pix_t;
  typedef logic [2:0][CS_W-1:0] csum_t;

  // One classified grid position, passed from the front end to the back end.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot_new;
    logic [SLOT_W-1:0] slot_old;
    pix_t              pix;
    logic              in_image;
    logic              col_in;
    logic              col_zero;
    logic              row_zero;
    logic              drop;
    logic              sub;
    logic [SLOT_W-1:0] tap_sel;
    logic              emit;
    logic [7:0]        n;
    logic              frame_end;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_CALC,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

@@ sv/ibb_front.sv @@
// Front end: accepts pixel transactions, tracks the padded grid position
// and classifies each position into a command. Depends on ibb_pkg.
module ibb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [11:0]          image_width,
  input  logic [12:0]          image_height,
  input  logic [2:0]           kernel_radius,
  input  logic                 pix_valid,
  input  logic [7:0]           chan0,
  input  logic [7:0]           chan1,
  input  logic [7:0]           chan2,
  input  logic                 q_full,
  output logic                 push,
  output ibb_pkg::cmd_t        cmd
);
  import ibb_pkg::*;

  logic [11:0]       scan_col, scan_col_next;
  logic [12:0]       scan_row, scan_row_next;
  logic [SLOT_W-1:0] row_slot, row_slot_next;

  logic [11:0] w_eff;
  logic [12:0] h_eff;
  logic [3:0]  span;
  logic [12:0] gw;
  logic [13:0] gh;
  logic [12:0] oy, y0, y_hi, y1;
  logic [11:0] ox, x0, x_hi, x1;
  logic [3:0]  cnt_y, cnt_x;
  logic [4:0]  slot_back;
  logic        col_wrap, row_wrap;

  always_comb begin
    if (image_width == 12'd0) w_eff = 12'd1;
    else if (image_width > 12'(MAX_WIDTH)) w_eff = 12'(MAX_WIDTH);
    else w_eff = image_width;
    if (image_height == 13'd0) h_eff = 13'd1;
    else if (image_height > 13'(HEIGHT_LIMIT)) h_eff = 13'(HEIGHT_LIMIT);
    else h_eff = image_height;
  end

  assign span = {kernel_radius, 1'b1};
  assign gw   = {1'b0, w_eff} + 13'(kernel_radius);
  assign gh   = {1'b0, h_eff} + 14'(kernel_radius);

  // Clipped window extent around the output pixel at (oy, ox).
  always_comb begin
    oy    = scan_row - 13'(kernel_radius);
    y0    = (oy > 13'(kernel_radius)) ? oy - 13'(kernel_radius) : 13'd0;
    y_hi  = oy + 13'(kernel_radius);
    y1    = (y_hi < h_eff - 13'd1) ? y_hi : h_eff - 13'd1;
    cnt_y = 4'(y1 - y0 + 13'd1);
    ox    = scan_col - 12'(kernel_radius);
    x0    = (ox > 12'(kernel_radius)) ? ox - 12'(kernel_radius) : 12'd0;
    x_hi  = ox + 12'(kernel_radius);
    x1    = (x_hi < w_eff - 12'd1) ? x_hi : w_eff - 12'd1;
    cnt_x = 4'(x1 - x0 + 12'd1);
    slot_back = 5'(row_slot) + 5'(STORE_ROWS) - 5'(span);
    if (slot_back >= 5'(STORE_ROWS)) slot_back = slot_back - 5'(STORE_ROWS);
  end

  always_comb begin
    cmd.col       = scan_col[COL_W-1:0];
    cmd.slot_new  = row_slot;
    cmd.slot_old  = slot_back[SLOT_W-1:0];
    cmd.pix       = {chan2, chan1, chan0};
    cmd.col_in    = scan_col < w_eff;
    cmd.in_image  = (scan_row < h_eff) && (scan_col < w_eff);
    cmd.col_zero  = scan_col == 12'd0;
    cmd.row_zero  = scan_row == 13'd0;
    cmd.drop      = scan_row >= 13'(span);
    cmd.sub       = scan_col >= 12'(span);
    cmd.tap_sel   = SLOT_W'({kernel_radius, 1'b0});
    cmd.emit      = (scan_row >= 13'(kernel_radius)) && (scan_col >= 12'(kernel_radius));
    cmd.n         = 8'(cnt_y) * 8'(cnt_x);
    cmd.frame_end = ({1'b0, scan_row} == gh - 14'd1) && ({1'b0, scan_col} == gw - 13'd1);
  end

  assign push     = pix_valid && !q_full;
  assign col_wrap = ({1'b0, scan_col} + 13'd1) >= gw;
  assign row_wrap = ({1'b0, scan_row} + 14'd1) >= gh;

  always_comb begin
    scan_col_next = scan_col;
    scan_row_next = scan_row;
    row_slot_next = row_slot;
    if (cfg_we) begin
      scan_col_next = '0;
      scan_row_next = '0;
      row_slot_next = '0;
    end else if (push) begin
      if (col_wrap) begin
        scan_col_next = '0;
        if (row_wrap) begin
          scan_row_next = '0;
          row_slot_next = '0;
        end else begin
          scan_row_next = scan_row + 13'd1;
          row_slot_next = (row_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : row_slot + 1'b1;
        end
      end else begin
        scan_col_next = scan_col + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_col <= '0;
      scan_row <= '0;
      row_slot <= '0;
    end else begin
      scan_col <= scan_col_next;
      scan_row <= scan_row_next;
      row_slot <= row_slot_next;
    end
  end

endmodule

@@ sv/ibb_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on ibb_pkg for the command type and depth.
module ibb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ibb_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output ibb_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);
  import ibb_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full   = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty  = count == '0;
  assign rd_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

@@ sv/ibb_back.sv @@
// Back end: column sum and line store update, window slide and the
// iterative mean division. Depends on ibb_pkg.
module ibb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  ibb_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          mean_valid,
  input  logic          mean_stall,
  output logic [7:0]    mean0,
  output logic [7:0]    mean1,
  output logic [7:0]    mean2,
  output logic          frame_end
);
  import ibb_pkg::*;

  back_state_t state, state_next;
  cmd_t        cmd;

  csum_t cs_mem [MAX_WIDTH];
  pix_t  st_mem [STORE_DEPTH];
  csum_t cs_rd;
  pix_t  st_rd;
  csum_t taps [STORE_ROWS];
  csum_t cs_new;

  logic [2:0][WIN_W-1:0] win, win_next;
  logic [2:0][WIN_W-1:0] rem;
  logic [2:0][7:0]       quo;
  logic [WIN_W-2:0]      dvs;
  logic [2:0]            step;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_empty) state_next = B_READ;
      B_READ: state_next = B_CALC;
      B_CALC: state_next = cmd.emit ? B_DIV : B_IDLE;
      B_DIV:  if (step == 3'd0) state_next = B_OUT;
      B_OUT:  if (!mean_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == B_IDLE) && !q_empty;
    mean_valid = state == B_OUT;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (pop) cmd <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (state == B_READ) begin
      cs_rd <= cs_mem[cmd.col];
      st_rd <= st_mem[STORE_AW'({cmd.slot_old, cmd.col})];
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [CS_W-1:0] fresh, old;
      fresh = cmd.in_image ? CS_W'(cmd.pix[ch]) : '0;
      old   = cmd.drop ? CS_W'(st_rd[ch]) : '0;
      cs_new[ch] = cmd.row_zero ? fresh : cs_rd[ch] + fresh - old;
      win_next[ch] = (cmd.col_zero ? '0 : win[ch])
                   + (cmd.col_in ? WIN_W'(cs_new[ch]) : '0)
                   - (cmd.sub ? WIN_W'(taps[cmd.tap_sel][ch]) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_CALC) begin
      if (cmd.col_in) cs_mem[cmd.col] <= cs_new;
      if (cmd.in_image) st_mem[STORE_AW'({cmd.slot_new, cmd.col})] <= cmd.pix;
    end
  end

  // The tap line holds the updated column sums of the last positions, so the
  // column leaving the window is found a span of positions back.
  always_ff @(posedge clk) begin
    if (state == B_CALC) begin
      win     <= win_next;
      taps[0] <= cmd.col_in ? cs_new : '0;
      for (int i = 1; i < STORE_ROWS; i++) taps[i] <= taps[i-1];
    end
  end

  // Restoring division, one quotient bit per cycle; the mean fits eight bits.
  always_ff @(posedge clk) begin
    if (state == B_CALC) begin
      rem  <= win_next;
      quo  <= '0;
      dvs  <= (WIN_W-1)'({cmd.n, 7'd0});
      step <= 3'd7;
      frame_end <= cmd.frame_end;
    end else if (state == B_DIV) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rem[ch] >= WIN_W'(dvs)) begin
          rem[ch] <= rem[ch] - WIN_W'(dvs);
          quo[ch] <= {quo[ch][6:0], 1'b1};
        end else begin
          quo[ch] <= {quo[ch][6:0], 1'b0};
        end
      end
      dvs  <= dvs >> 1;
      step <= step - 3'd1;
    end
  end

  assign mean0 = quo[0];
  assign mean1 = quo[1];
  assign mean2 = quo[2];

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |-> cmd.n != 8'd0)
    else $error("division started with a zero pixel count");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_OUT |-> (rem[0] < WIN_W'(cmd.n)) && (rem[1] < WIN_W'(cmd.n))
                       && (rem[2] < WIN_W'(cmd.n)))
    else $error("division remainder not below the pixel count");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    state == B_CALC && !cmd.emit |=> state == B_IDLE)
    else $error("position without result did not return to idle");

endmodule

@@ sv/integral_box_blur_unit.sv @@
// Streaming box mean blur over a padded raster grid of (width+r) x (height+r).
// The back end takes a queued position only once the previous one has been through
// its memory read/update sequence and, with a result, the 8-step divider and output.
// Reset: synchronous; grid counters, queue and control clear, registers load
// 640 x 480 with radius 2. No clearing pass; any register write restarts the frame.
module integral_box_blur_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        pix_valid,
  output logic        pix_stall,
  input  logic [7:0]  chan0,
  input  logic [7:0]  chan1,
  input  logic [7:0]  chan2,
  input  logic        flush,
  output logic        mean_valid,
  input  logic        mean_stall,
  output logic [7:0]  mean0,
  output logic [7:0]  mean1,
  output logic [7:0]  mean2,
  output logic        frame_end
);
  import ibb_pkg::*;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [2:0]  kernel_radius;
  logic        push, pop, q_full, q_empty;
  cmd_t        f_cmd, q_cmd;
  logic        unused_flush;

  // Padding is decided by grid position alone.
  assign unused_flush = flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 12'd640;
      image_height  <= 13'd480;
      kernel_radius <= 3'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width   <= cfg_data[11:0];
        REG_HEIGHT: image_height  <= cfg_data;
        REG_RADIUS: kernel_radius <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign pix_stall = q_full;

  ibb_front u_front (
    .clk, .rst, .cfg_we, .image_width, .image_height, .kernel_radius,
    .pix_valid, .chan0, .chan1, .chan2, .q_full, .push, .cmd(f_cmd)
  );

  ibb_queue u_queue (
    .clk, .rst, .push, .wr_cmd(f_cmd), .pop, .rd_cmd(q_cmd),
    .full(q_full), .empty(q_empty)
  );

  ibb_back u_back (
    .clk, .rst, .q_empty, .q_cmd, .pop, .mean_valid, .mean_stall,
    .mean0, .mean1, .mean2, .frame_end
  );

endmodule

@@ bench/ibb_blur_checker.sv @@
// Checker for the integral box blur unit: follows the register port and all three
// pixel channels, predicts each blurred pixel and compares it on arrival.
// Depends on ibb_pkg for the register indexes and the size constants.
module ibb_blur_checker
  import ibb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        pix_valid,
  input  logic        pix_stall,
  input  logic [7:0]  chan0,
  input  logic [7:0]  chan1,
  input  logic [7:0]  chan2,
  input  logic        flush,
  input  logic        mean_valid,
  input  logic        mean_stall,
  input  logic [7:0]  mean0,
  input  logic [7:0]  mean1,
  input  logic [7:0]  mean2,
  input  logic        frame_end,
  output int          errors,
  output int          pending,
  output int          checked
);

  typedef struct {
    bit [2:0][7:0] mean;
    bit            last;
  } blur_px_t;

  bit [11:0]          width_reg;
  bit [12:0]          height_reg;
  bit [2:0]           radius_reg;
  bit [2:0][7:0]      line_mem [STORE_DEPTH];
  bit [2:0][31:0]     col_sum  [MAX_WIDTH];
  bit [2:0][31:0]     win_sum;
  int unsigned        scan_row;
  int unsigned        scan_col;
  blur_px_t           blur_q[$];

  assign pending = blur_q.size();

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
    errors++;
  endtask

  task automatic blur_pixel(input bit [2:0][7:0] px);
    int unsigned w, h, r, span, row, col, oy, ox, y0, y1, x0, x1, n, fresh, old;
    int unsigned idx_new, idx_old;
    bit in_image, drop;
    blur_px_t e;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
    r = radius_reg;
    span = 2 * r + 1;
    if (scan_col >= w + r) scan_col = 0;
    if (scan_row >= h + r) scan_row = 0;
    row = scan_row;
    col = scan_col;
    in_image = (row < h) && (col < w);
    if (col < w) begin
      idx_new = (row % STORE_ROWS) * MAX_WIDTH + col;
      drop = (row >= span) && (row - span < h);
      idx_old = drop ? ((row - span) % STORE_ROWS) * MAX_WIDTH + col : 0;
      for (int c = 0; c < 3; c++) begin
        fresh = in_image ? px[c] : 0;
        old = drop ? line_mem[idx_old][c] : 0;
        col_sum[col][c] = (row == 0) ? fresh : col_sum[col][c] + fresh - old;
      end
      if (in_image) line_mem[idx_new] = px;
    end
    // The window sum slides along the row; it restarts at each row start.
    if (col == 0) win_sum = '0;
    for (int c = 0; c < 3; c++) begin
      if (col < w) win_sum[c] += col_sum[col][c];
      if (col >= span && col - span < w) win_sum[c] -= col_sum[col - span][c];
    end
    if (row >= r && col >= r) begin
      oy = row - r;
      ox = col - r;
      y0 = (oy > r) ? oy - r : 0;
      y1 = (oy + r < h - 1) ? oy + r : h - 1;
      x0 = (ox > r) ? ox - r : 0;
      x1 = (ox + r < w - 1) ? ox + r : w - 1;
      n = (y1 - y0 + 1) * (x1 - x0 + 1);
      for (int c = 0; c < 3; c++) e.mean[c] = 8'(win_sum[c] / n);
      e.last = (row == h + r - 1) && (col == w + r - 1);
      blur_q.push_back(e);
    end
    scan_col = col + 1;
    if (scan_col >= w + r) begin
      scan_col = 0;
      scan_row = row + 1;
      if (scan_row >= h + r) scan_row = 0;
    end
  endtask

  always @(posedge clk) begin
    blur_px_t e;
    if (rst) begin
      width_reg = 640;
      height_reg = 480;
      radius_reg = 2;
      for (int i = 0; i < MAX_WIDTH; i++) col_sum[i] = '0;
      win_sum = '0;
      scan_row = 0;
      scan_col = 0;
      blur_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_reg = cfg_data[11:0];
          REG_HEIGHT: height_reg = cfg_data;
          REG_RADIUS: radius_reg = cfg_data[2:0];
          default: ;
        endcase
        // Any write, even to an unused index, restarts the frame.
        scan_row = 0;
        scan_col = 0;
        win_sum = '0;
      end
      if (pix_valid && !pix_stall) blur_pixel({chan2, chan1, chan0});
      if (mean_valid && !mean_stall) begin
        if (blur_q.size() == 0) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          e = blur_q.pop_front();
          if (mean0 !== e.mean[0]) report("mean0", mean0, e.mean[0]);
          if (mean1 !== e.mean[1]) report("mean1", mean1, e.mean[1]);
          if (mean2 !== e.mean[2]) report("mean2", mean2, e.mean[2]);
          if (frame_end !== e.last) report("frame_end", frame_end, e.last);
        end
        checked++;
      end
    end
  end

endmodule

@@ bench/tb_integral_box_blur_unit.sv @@
// Top of the blur unit testbench: clock, reset, register writes and pixel stimulus.
// Depends on ibb_pkg, integral_box_blur_unit and ibb_blur_checker.
module tb_integral_box_blur_unit;
  import ibb_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int unsigned ITEM_TARGET = 1750;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        pix_valid = 1'b0;
  logic        pix_stall;
  logic [7:0]  chan0 = '0, chan1 = '0, chan2 = '0;
  logic        flush = 1'b0;
  logic        mean_valid;
  logic        mean_stall = 1'b0;
  logic [7:0]  mean0, mean1, mean2;
  logic        frame_end;
  int          errors, pending, checked;

  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned phases = 0;
  int unsigned burst_left = 0;
  int unsigned img_w = 640, img_h = 480, img_r = 2;
  int unsigned pos_row = 0, pos_col = 0;

  integral_box_blur_unit i_dut (.*);

  ibb_blur_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stall: switches among free flow, light and heavy stalling.
  int unsigned stall_mode = 0, stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 300);
    end
    stall_left--;
    case (stall_mode)
      0: mean_stall <= 1'b0;
      1: mean_stall <= ($urandom_range(0, 3) == 0);
      default: mean_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  img_w = (val[11:0] == 0) ? 1 : (val[11:0] > MAX_WIDTH) ? MAX_WIDTH : val[11:0];
      REG_HEIGHT: img_h = (val == 0) ? 1 : (val > HEIGHT_LIMIT) ? HEIGHT_LIMIT : val;
      REG_RADIUS: img_r = val[2:0];
      default: ;
    endcase
    pos_row = 0;
    pos_col = 0;
  endtask

  // Waits until every expected result has come and the pipeline has drained.
  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sends one pixel; the flush bit follows the grid position unless noisy.
  task automatic send_pixel(input logic [7:0] c0, c1, c2, input bit noisy);
    if (burst_left == 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    pix_valid <= 1'b1;
    chan0 <= c0;
    chan1 <= c1;
    chan2 <= c2;
    flush <= noisy ? 1'($urandom) : !(pos_row < img_h && pos_col < img_w);
    do @(posedge clk); while (pix_stall);
    burst_left--;
    sent++;
    pos_col++;
    if (pos_col >= img_w + img_r) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= img_h + img_r) pos_row = 0;
    end
  endtask

  task automatic idle_sender();
    pix_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned frame_len, count;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single pixel image with no blur, channels 0 and 2 full scale, channel 1 zero.
    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'd1);
    write_reg(REG_RADIUS, 13'd0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    idle_sender();
    settle();
    // Two pixels, radius one, then a restart through the unused index.
    write_reg(REG_WIDTH, 13'd2);
    write_reg(REG_RADIUS, 13'd1);
    for (int i = 0; i < 3; i++) send_pixel(8'd255, 8'd1, 8'd0, 1'b0);
    idle_sender();
    settle();
    write_reg(REG_UNUSED, 13'h1fff);
    for (int i = 0; i < 6; i++) send_pixel(8'd0, 8'd128, 8'd255, 1'b0);
    idle_sender();
    settle();
    // Zero registers clamp to one pixel; flush bits set wrongly are ignored.
    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'd0);
    write_reg(REG_RADIUS, 13'd0);
    send_pixel(8'd77, 8'd200, 8'd3, 1'b1);
    send_pixel(8'd1, 8'd2, 8'd254, 1'b1);
    idle_sender();
    settle();
    // Oversized registers clamp; only the first eight positions of this frame are sent.
    write_reg(REG_WIDTH, 13'h0fff);
    write_reg(REG_HEIGHT, 13'h1fff);
    write_reg(REG_RADIUS, 13'd7);
    for (int i = 0; i < 8; i++) send_pixel(pick_level(), pick_level(), pick_level(), 1'b0);
    idle_sender();
    settle();
    phases = 5;

    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: write_reg(REG_WIDTH, 13'($urandom_range(0, 4095)));
        1: write_reg(REG_UNUSED, 13'($urandom));
        default: write_reg(REG_WIDTH, 13'($urandom_range(1, 20)));
      endcase
      if ($urandom_range(0, 15) == 0) write_reg(REG_HEIGHT, 13'($urandom));
      else write_reg(REG_HEIGHT, 13'($urandom_range(1, 10)));
      write_reg(REG_RADIUS, 13'($urandom_range(0, 7)) | 13'($urandom_range(0, 1023) << 3));
      frame_len = (img_w + img_r) * (img_h + img_r);
      if (frame_len <= 400 && $urandom_range(0, 9) != 0)
        count = frame_len * $urandom_range(1, 2);
      else
        count = $urandom_range(20, 250);
      if (count > ITEM_TARGET - sent) count = ITEM_TARGET - sent;
      for (int i = 0; i < count; i++)
        send_pixel(pick_level(), pick_level(), pick_level(), $urandom_range(0, 9) == 0);
      idle_sender();
      settle();
      phases++;
    end

    $display("Sent %0d pixel transactions in %0d register settings,", sent, phases);
    $display("radius 0 to 7, clipped borders and clamped sizes; %0d results compared.",
             checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
